// ===== sv/m4i_pkg.sv =====
// Package with shared constants and types for the 4x4 cofactor inverse.
package m4i_pkg;

  localparam int ELEM_W   = 32;
  localparam int MAT_N    = 4;
  localparam int LANES    = 4;

  // Lane control type: a start flag and a row select.
  typedef struct packed {
    logic       start;
    logic [1:0] row;
  } lane_ctrl_t;

  // Result element with its clip flag.
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              clipped;
  } lane_res_t;

endpackage

// ===== sv/m4i_if.sv =====
// Valid/ready channel interface carrying one matrix row word.
interface m4i_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] first_elem;
  logic [W-1:0] second_elem;
  logic [W-1:0] third_elem;
  logic [W-1:0] fourth_elem;
  logic [W-1:0] determinant_value;
  logic         singular;
  logic         saturated;
  logic         last_row;

  modport source (
    output valid, first_elem, second_elem, third_elem, fourth_elem,
           determinant_value, singular, saturated, last_row,
    input  ready
  );
  modport sink (
    input  valid, first_elem, second_elem, third_elem, fourth_elem,
           determinant_value, singular, saturated, last_row,
    output ready
  );
endinterface

// ===== sv/m4i_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
module m4i_div #(
  parameter int NW = 160,
  parameter int DW = 130
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [NW-1:0] shq;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem[DW-1:0], shq[NW-1]};
  end

  // Shift in one numerator bit, subtract when the remainder allows.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      rem  <= '0;
      shq  <= num;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        shq <= {shq[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        shq <= {shq[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = shq;
endmodule

// ===== sv/m4i_lane.sv =====
// One lane: forms a row of cofactors by sequential products, then divides.
module m4i_lane #(
  parameter int EW = 32,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [16*EW-1:0]      mat,
  input  logic [1:0]            lane_col,
  input  logic                  cof_start,
  output logic                  cof_done,
  output logic signed [4*EW+3:0] cof0,
  input  logic                  div_start,
  input  logic [4*EW+1:0]       det_mag,
  input  logic                  det_neg,
  input  logic [1:0]            div_row,
  output logic                  div_done,
  output logic [EW-1:0]         res_value,
  output logic                  res_clip
);
  import m4i_pkg::*;

  localparam int CWD = 3*EW + 3;
  localparam int NW  = 3*EW + 2*FB + 4;
  localparam int DW  = 4*EW + 2;

  // Cofactor of element (lane_col, cr) for cr = 0..3, computed in sequence.
  // Lane c keeps cof[c][r] in cofs[r], which is adjugate element (r, c), so
  // the lane serves output column c directly.
  logic signed [CWD-1:0] cofs [4];
  logic [1:0]  cr;
  logic [2:0]  pi;
  logic [1:0]  mi;
  logic [1:0]  mk;
  logic        busy;
  logic signed [EW-1:0]   fa;
  logic                   aneg;
  logic [EW-1:0]          amag;
  logic [2*EW-1:0]        pm;
  logic                   psgn;
  logic [3*EW-1:0]        tm;
  logic [EW-1:0]          mb;
  logic [2*EW-1:0]        mprod;
  logic [3*EW-1:0]        tri3;
  logic signed [CWD-1:0]  acc;
  logic signed [CWD-1:0]  acc_next;
  logic [1:0] rr [3];
  logic [1:0] cc [3];
  logic [1:0] pc;
  logic       pneg;

  // Row and column picks that remain after deleting lane_col and cr.
  always_comb begin
    mk = (mi == 2'd3) ? 2'd2 : mi;
    for (int i = 0; i < 3; i++) begin
      rr[i] = (2'(i) >= lane_col) ? 2'(i + 1) : 2'(i);
      cc[i] = (2'(i) >= cr)       ? 2'(i + 1) : 2'(i);
    end
    case (pi)
      3'd0: pc = (mk == 2'd0) ? 2'd0 : (mk == 2'd1) ? 2'd1 : 2'd2;
      3'd1: pc = (mk == 2'd0) ? 2'd1 : (mk == 2'd1) ? 2'd2 : 2'd0;
      3'd2: pc = (mk == 2'd0) ? 2'd2 : (mk == 2'd1) ? 2'd0 : 2'd1;
      3'd3: pc = (mk == 2'd0) ? 2'd0 : (mk == 2'd1) ? 2'd2 : 2'd1;
      3'd4: pc = (mk == 2'd0) ? 2'd1 : (mk == 2'd1) ? 2'd0 : 2'd2;
      default: pc = (mk == 2'd0) ? 2'd2 : (mk == 2'd1) ? 2'd1 : 2'd0;
    endcase
    fa   = mat[({rr[mk], cc[pc]})*EW +: EW];
    aneg = fa[EW-1];
    amag = aneg ? EW'(-fa) : EW'(fa);
    pneg = (pi >= 3'd3) ^ cr[0] ^ lane_col[0];
    // One shared multiplier on magnitudes: low half of the running product,
    // then its high half on the last step.
    mb       = (mi == 2'd3) ? pm[2*EW-1:EW] : pm[EW-1:0];
    mprod    = amag * mb;
    tri3     = tm + {mprod, {EW{1'b0}}};
    acc_next = psgn ? acc - $signed(CWD'(tri3)) : acc + $signed(CWD'(tri3));
  end

  // Product chain: four steps per triple product, registered between steps.
  always_ff @(posedge clk) begin
    cof_done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (cof_start) begin
      busy <= 1'b1;
      cr <= 2'd0; pi <= 3'd0; mi <= 2'd0;
      acc <= '0;
    end else if (busy) begin
      case (mi)
        2'd0: begin
          pm   <= (2*EW)'(amag);
          psgn <= aneg ^ pneg;
          mi   <= 2'd1;
        end
        2'd1: begin
          pm   <= mprod;
          psgn <= psgn ^ aneg;
          mi   <= 2'd2;
        end
        2'd2: begin
          tm   <= (3*EW)'(mprod);
          psgn <= psgn ^ aneg;
          mi   <= 2'd3;
        end
        default: begin
          mi <= 2'd0;
          if (pi == 3'd5) begin
            cofs[cr] <= acc_next;
            acc <= '0;
            pi <= 3'd0;
            if (cr == 2'd3) begin
              busy <= 1'b0;
              cof_done <= 1'b1;
            end
            cr <= cr + 1'b1;
          end else begin
            acc <= acc_next;
            pi <= pi + 1'b1;
          end
        end
      endcase
    end
  end

  assign cof0 = (4*EW+4)'(cofs[0]);

  // Divide |adj| << 2F by |det| for the selected output row.
  logic signed [CWD-1:0] sel;
  logic                  nneg;
  logic [CWD-1:0]        nmag;
  logic [NW-1:0]         quo;
  logic                  dn;
  logic                  sgn;
  logic [NW-1:0]         lim;

  always_comb begin
    sel  = cofs[div_row];
    nneg = sel[CWD-1];
    nmag = nneg ? CWD'(-sel) : CWD'(sel);
  end

  always_ff @(posedge clk) begin
    if (div_start) sgn <= nneg ^ det_neg;
  end

  m4i_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NW'(nmag) << (2*FB)), .den(det_mag),
    .done(dn), .quo(quo)
  );

  // Clip to the element range, truncation already toward zero.
  always_comb begin
    lim = (NW'(1) << (EW-1)) - (sgn ? NW'(0) : NW'(1));
    if (quo > lim) begin
      res_value = sgn ? EW'(-lim) : EW'(lim);
      res_clip  = 1'b1;
    end else begin
      res_value = sgn ? EW'(-quo) : EW'(quo);
      res_clip  = 1'b0;
    end
  end
  assign div_done = dn;
endmodule

// ===== sv/matrix4_inverse_cofactor.sv =====
// Top level of the 4x4 fixed-point matrix inverse by cofactors.
//
//  channel | dir | payload
//  in_ch   | in  | first_elem .. fourth_elem (one matrix row)
//  out_ch  | out | first..fourth, determinant_value, singular, saturated, last_row
//
// Rows are stored as they arrive, ready being high while loading. After
// row four the four lanes form their cofactor rows with a multiply chain,
// the determinant is merged limb by limb, then, unless the determinant is
// zero, each output row takes one division of 3*W+2F+4 quotient bits, in
// all lanes at once. Input is held off until the last result row leaves;
// the output holds while not ready.
// Synchronous active-high reset clears the sequencer and the row count.
module matrix4_inverse_cofactor #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  m4i_if.sink   in_ch,
  m4i_if.source out_ch
);
  import m4i_pkg::*;

  localparam int EW = ELEM_WIDTH;
  localparam int CW = 4*EW + 4;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state;
  logic [1:0]        row_count;
  logic [1:0]        orow;
  logic [16*EW-1:0]  mat;
  logic [3:0]        cdone_seen;
  logic [3:0]        ddone_seen;
  logic [3:0]        cdone;
  logic [3:0]        ddone;
  logic signed [CW-1:0] c0 [4];
  logic [EW-1:0]     rv [4];
  logic [3:0]        rc;
  logic signed [CW-1:0] det;
  logic [CW-1:0]     dmag;
  logic              dneg;
  logic              sing;
  logic [1:0]        dstep;
  logic [1:0]        dlimb;
  logic              go_cof;
  logic              go_div;

  assign in_ch.ready = (state == S_LOAD);

  // Store the incoming row.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mat[{row_count, 2'd0}*EW +: EW] <= in_ch.first_elem;
      mat[{row_count, 2'd1}*EW +: EW] <= in_ch.second_elem;
      mat[{row_count, 2'd2}*EW +: EW] <= in_ch.third_elem;
      mat[{row_count, 2'd3}*EW +: EW] <= in_ch.fourth_elem;
    end
  end

  // Lanes, one per column of the adjugate matrix.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    m4i_lane #(.EW(EW), .FB(FRAC_BITS)) u_lane (
      .clk(clk), .rst(rst), .mat(mat), .lane_col(2'(g)),
      .cof_start(go_cof), .cof_done(cdone[g]), .cof0(c0[g]),
      .div_start(go_div), .det_mag(dmag[4*EW+1:0]), .det_neg(dneg),
      .div_row(orow), .div_done(ddone[g]),
      .res_value(rv[g]), .res_clip(rc[g])
    );
  end

  // Determinant clip: |det| >> 3F, saturated.
  logic [CW-1:0] dsh;
  logic [CW-1:0] dlim;
  always_comb begin
    dsh  = dmag >> (3*FRAC_BITS);
    dlim = (CW'(1) << (EW-1)) - (dneg ? CW'(0) : CW'(1));
  end

  // Determinant term along column 0: one element-wide limb of the cofactor
  // magnitude times the element magnitude per cycle.
  logic signed [CW-1:0] dcof;
  logic [CW-1:0]        dcmag;
  logic signed [EW-1:0] delem;
  logic [EW-1:0]        demag;
  logic                 dpneg;
  logic [2*EW-1:0]      dprod;
  logic [CW-1:0]        dterm;
  always_comb begin
    dcof  = c0[dstep];
    delem = mat[{dstep, 2'd0}*EW +: EW];
    dcmag = dcof[CW-1] ? CW'(-dcof) : CW'(dcof);
    demag = delem[EW-1] ? EW'(-delem) : EW'(delem);
    dpneg = dcof[CW-1] ^ delem[EW-1];
    dprod = demag * dcmag[dlimb*EW +: EW];
    dterm = CW'(dprod) << (dlimb*EW);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    go_cof <= 1'b0;
    go_div <= 1'b0;
    if (rst) begin
      state <= S_LOAD;
      row_count <= 2'd0;
      out_ch.valid <= 1'b0;
      cdone_seen <= '0;
      ddone_seen <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_ch.valid) begin
            row_count <= row_count + 1'b1;
            if (row_count == 2'd3) begin
              state <= S_COF;
              go_cof <= 1'b1;
              cdone_seen <= '0;
            end
          end
        end
        S_COF: begin
          cdone_seen <= cdone_seen | cdone;
          if ((cdone_seen | cdone) == 4'hf) begin
            state <= S_DET;
            dstep <= 2'd0;
            dlimb <= 2'd0;
            det <= '0;
          end
        end
        S_DET: begin
          // Merge the lane results, one partial product per cycle.
          det <= dpneg ? det - $signed(dterm) : det + $signed(dterm);
          if (dlimb == 2'd2) begin
            dlimb <= 2'd0;
            dstep <= dstep + 1'b1;
            if (dstep == 2'd3) state <= S_WAIT;
          end else begin
            dlimb <= dlimb + 1'b1;
          end
        end
        S_WAIT: begin
          dneg <= det[CW-1];
          dmag <= det[CW-1] ? CW'(-det) : CW'(det);
          sing <= (det == '0);
          orow <= 2'd0;
          state <= S_DIV;
          go_div <= (det != '0);
          ddone_seen <= '0;
        end
        S_DIV: begin
          ddone_seen <= ddone_seen | ddone;
          if (sing || (ddone_seen | ddone) == 4'hf) begin
            state <= S_OUT;
            out_ch.valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (orow == 2'd3) begin
              state <= S_LOAD;
            end else begin
              orow <= orow + 1'b1;
              state <= S_DIV;
              go_div <= !sing;
              ddone_seen <= '0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output word for the current row.
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      if (sing) begin
        out_ch.first_elem  <= mat[{orow, 2'd0}*EW +: EW];
        out_ch.second_elem <= mat[{orow, 2'd1}*EW +: EW];
        out_ch.third_elem  <= mat[{orow, 2'd2}*EW +: EW];
        out_ch.fourth_elem <= mat[{orow, 2'd3}*EW +: EW];
        out_ch.determinant_value <= '0;
        out_ch.saturated <= 1'b0;
      end else begin
        out_ch.first_elem  <= rv[0];
        out_ch.second_elem <= rv[1];
        out_ch.third_elem  <= rv[2];
        out_ch.fourth_elem <= rv[3];
        out_ch.determinant_value <= (dsh > dlim) ? (dneg ? EW'(-dlim) : EW'(dlim))
                                                 : (dneg ? EW'(-dsh) : EW'(dsh));
        out_ch.saturated <= (|rc) | (dsh > dlim);
      end
      out_ch.singular <= sing;
      out_ch.last_row <= (orow == 2'd3);
    end
  end
endmodule
